[hw/rtl/tpq_pkg.sv]
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and codes for the two-level priority FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package tpq_pkg;

    // request kinds carried in tuser
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // field widths fixed by the interface
    localparam int unsigned ITEM_W  = 16;
    localparam int unsigned COUNT_W = 5;

    // depth of the command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PW    = 1;

    // command issued by the front: what the back does and the result fields
    typedef struct packed {
        logic               wr_en;       // write store entry
        logic               rd_en;       // read store entry into result
        logic               out_high;    // level of the dequeued word
        logic [1:0]         status;
        logic [COUNT_W-1:0] item_count;
        logic               queue_empty;
    } t_cmd_meta;

endpackage

`default_nettype wire

[hw/rtl/two_level_priority_fifo.sv]
// ----------------------------------------------------------------------------
// two_level_priority_fifo
// Two-level priority queue, first in first out within each level.
//
// Request beats enter on the s_axis channel: tuser[0] is the kind
// (0 enqueue, 1 dequeue), tuser[1] the level of an enqueued word and
// tdata[15:0] the word. Every request gives one result beat on m_axis with
// the dequeued word, its level, a status, the count held and an empty flag.
// High-level words always leave before low-level ones; an enqueue with
// CAPACITY words held is dropped with status full, a dequeue with none held
// returns status empty.
// Throughput: one request per cycle while the command queue has room; the
// front updates the ring pointers in the cycle a beat is accepted; the back
// does one memory access per cycle while its result register can be loaded.
// Each request passes the command queue register, then the registered read.
// Reset clears pointers, counts and the command queue; the word memory is
// not cleared, as only written entries are ever read.
// A stalled receiver holds the result beat; the command queue fills and
// then s_axis tready drops until the receiver takes beats again.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_priority_fifo
    import tpq_pkg::*;
#(
    parameter int unsigned CAPACITY   = 16,
    parameter int unsigned DATA_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // item_data
    input  wire logic [1:0]  i_s_axis_tuser,   // req_type, is_high
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // out_data, status, item_count, queue_empty
    output logic [0:0]       o_m_axis_tuser    // out_high
);

    localparam int unsigned STORE_W = (DATA_WIDTH < ITEM_W) ? DATA_WIDTH : ITEM_W;
    localparam int unsigned AW      = $clog2(CAPACITY) + 1;
    localparam int unsigned Q_W     = $bits(t_cmd_meta) + AW + STORE_W;

    logic               push_valid, push_ready;
    t_cmd_meta          push_meta, pop_meta, res_meta;
    logic [AW-1:0]      push_addr, pop_addr;
    logic [STORE_W-1:0] push_data, pop_data;
    logic               pop_valid, pop_req;
    logic [ITEM_W-1:0]  res_data;

    tpq_front #(
        .CAPACITY (CAPACITY),
        .STORE_W  (STORE_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_req_type  (i_s_axis_tuser[0]),
        .i_item_data (i_s_axis_tdata),
        .i_is_high   (i_s_axis_tuser[1]),
        .o_cmd_valid (push_valid),
        .i_cmd_ready (push_ready),
        .o_cmd_meta  (push_meta),
        .o_cmd_addr  (push_addr),
        .o_cmd_data  (push_data)
    );

    tpq_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_valid),
        .o_ready (push_ready),
        .i_data  ({push_meta, push_addr, push_data}),
        .o_valid (pop_valid),
        .i_pop   (pop_req),
        .o_data  ({pop_meta, pop_addr, pop_data})
    );

    tpq_back #(
        .CAPACITY (CAPACITY),
        .STORE_W  (STORE_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .o_cmd_pop   (pop_req),
        .i_cmd_meta  (pop_meta),
        .i_cmd_addr  (pop_addr),
        .i_cmd_data  (pop_data),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_out_data  (res_data),
        .o_meta      (res_meta)
    );

    // result beat packing
    assign o_m_axis_tdata = {res_meta.queue_empty, res_meta.item_count,
                             res_meta.status, res_data};
    assign o_m_axis_tuser = res_meta.out_high;

endmodule

`default_nettype wire

[hw/rtl/tpq_front.sv]
// ----------------------------------------------------------------------------
// tpq_front
// Accepts requests, keeps the ring pointers and level counts, decides the
// outcome of each request and issues a store command to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_front
    import tpq_pkg::*;
#(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned STORE_W  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_req_type,
    input  wire logic [ITEM_W-1:0]             i_item_data,
    input  wire logic                          i_is_high,
    output logic                               o_cmd_valid,
    input  wire logic                          i_cmd_ready,
    output t_cmd_meta                          o_cmd_meta,
    output logic [$clog2(CAPACITY):0]          o_cmd_addr,
    output logic [STORE_W-1:0]                 o_cmd_data
);

    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [IW-1:0] r_high_head, r_high_tail, r_low_head, r_low_tail;
    logic [IW-1:0] n_high_head, n_high_tail, n_low_head, n_low_tail;
    logic [CW-1:0] r_high_cnt, r_low_cnt, n_high_cnt, n_low_cnt;
    logic [CW:0]   total, n_total;
    logic [CW+COUNT_W:0] count_ext;
    logic [ITEM_W+STORE_W-1:0] word_ext;
    logic          accept;

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
        ring_next = (idx == IW'(CAPACITY - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign o_ready     = i_cmd_ready;
    assign accept      = i_valid & i_cmd_ready;
    assign o_cmd_valid = accept;

    // keep the low bits of the word that the store holds
    assign word_ext   = {{STORE_W{1'b0}}, i_item_data};
    assign o_cmd_data = word_ext[STORE_W-1:0];

    // decide the outcome of the request
    always_comb begin
        n_high_head = r_high_head;
        n_high_tail = r_high_tail;
        n_low_head  = r_low_head;
        n_low_tail  = r_low_tail;
        n_high_cnt  = r_high_cnt;
        n_low_cnt   = r_low_cnt;
        o_cmd_addr  = '0;
        o_cmd_meta  = '0;
        o_cmd_meta.status = ST_OK;
        total = {1'b0, r_high_cnt} + {1'b0, r_low_cnt};

        if (i_req_type == REQ_ENQ) begin
            if (total >= (CW+1)'(CAPACITY)) begin
                o_cmd_meta.status = ST_FULL;
            end else if (i_is_high) begin
                o_cmd_meta.wr_en = 1'b1;
                o_cmd_addr  = {1'b1, r_high_tail};
                n_high_tail = ring_next(r_high_tail);
                n_high_cnt  = r_high_cnt + 1'b1;
            end else begin
                o_cmd_meta.wr_en = 1'b1;
                o_cmd_addr  = {1'b0, r_low_tail};
                n_low_tail  = ring_next(r_low_tail);
                n_low_cnt   = r_low_cnt + 1'b1;
            end
        end else begin
            if (r_high_cnt != '0) begin
                o_cmd_meta.rd_en    = 1'b1;
                o_cmd_meta.out_high = 1'b1;
                o_cmd_addr  = {1'b1, r_high_head};
                n_high_head = ring_next(r_high_head);
                n_high_cnt  = r_high_cnt - 1'b1;
            end else if (r_low_cnt != '0) begin
                o_cmd_meta.rd_en = 1'b1;
                o_cmd_addr  = {1'b0, r_low_head};
                n_low_head  = ring_next(r_low_head);
                n_low_cnt   = r_low_cnt - 1'b1;
            end else begin
                o_cmd_meta.status = ST_EMPTY;
            end
        end

        n_total   = {1'b0, n_high_cnt} + {1'b0, n_low_cnt};
        count_ext = {{COUNT_W{1'b0}}, n_total};
        o_cmd_meta.item_count  = count_ext[COUNT_W-1:0];
        o_cmd_meta.queue_empty = (n_total == '0);
    end

    // pointer and count state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_head <= '0;
            r_high_tail <= '0;
            r_low_head  <= '0;
            r_low_tail  <= '0;
            r_high_cnt  <= '0;
            r_low_cnt   <= '0;
        end else if (accept) begin
            r_high_head <= n_high_head;
            r_high_tail <= n_high_tail;
            r_low_head  <= n_low_head;
            r_low_tail  <= n_low_tail;
            r_high_cnt  <= n_high_cnt;
            r_low_cnt   <= n_low_cnt;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tpq_queue.sv]
// ----------------------------------------------------------------------------
// tpq_queue
// Short command queue between front and back, so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_queue
    import tpq_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0]      r_slot [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QUEUE_PW:0]     r_cnt;
    logic                  do_push, do_pop;

    assign o_ready = (r_cnt != (QUEUE_PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tpq_back.sv]
// ----------------------------------------------------------------------------
// tpq_back
// Carries out store commands on the word memory and holds the result beat
// in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_back
    import tpq_pkg::*;
#(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned STORE_W  = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cmd_valid,
    output logic                           o_cmd_pop,
    input  wire t_cmd_meta                 i_cmd_meta,
    input  wire logic [$clog2(CAPACITY):0] i_cmd_addr,
    input  wire logic [STORE_W-1:0]        i_cmd_data,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [ITEM_W-1:0]              o_out_data,
    output t_cmd_meta                      o_meta
);

    localparam int unsigned AW        = $clog2(CAPACITY) + 1;
    localparam int unsigned MEM_DEPTH = 1 << AW;

    // both levels share one memory, level bit on top of the address
    logic [STORE_W-1:0]        r_store [MEM_DEPTH];
    logic [STORE_W-1:0]        r_rd_data;
    t_cmd_meta                 r_meta;
    logic                      r_valid;
    logic [ITEM_W+STORE_W-1:0] rd_ext;

    assign o_cmd_pop = i_cmd_valid & (!r_valid | i_ready);
    assign o_valid   = r_valid;
    assign o_meta    = r_meta;
    assign rd_ext    = {{ITEM_W{1'b0}}, r_rd_data};
    assign o_out_data = r_meta.rd_en ? rd_ext[ITEM_W-1:0] : '0;

    // word memory, read data registered as the result word
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            if (i_cmd_meta.wr_en) begin
                r_store[i_cmd_addr] <= i_cmd_data;
            end
            if (i_cmd_meta.rd_en) begin
                r_rd_data <= r_store[i_cmd_addr];
            end
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_meta <= i_cmd_meta;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[test/two_level_priority_fifo_tb.sv]
// ----------------------------------------------------------------------------
// two_level_priority_fifo_tb
// Self-checking bench for the two-level priority FIFO.
//
// Request beats go in on the slave stream in bursts with random gaps. The
// result stream is throttled by a stall pattern that changes over the run.
// A scoreboard keeps its own two-level queue, works out the result of every
// accepted request and compares each result beat with it, field by field.
// A short directed run covers the word extremes, both levels, a dequeue
// with nothing held and an enqueue with the queue full. Random phases
// follow that lean towards filling, draining or a mix, so the queue hits
// full and empty many times.
// ----------------------------------------------------------------------------

module two_level_priority_fifo_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tpq_pkg::*;

    localparam int unsigned FIFO_CAPACITY = 16;
    localparam int unsigned RANDOM_ITEMS  = 700;
    localparam int unsigned DRAIN_CYCLES  = 8;

    // result stall pattern of the receiver
    typedef enum logic [1:0] {
        RX_FREE   = 2'd0,
        RX_MOSTLY = 2'd1,
        RX_SPARSE = 2'd2,
        RX_HALT   = 2'd3
    } rx_pace_e;

    // one expected result beat
    typedef struct packed {
        logic [15:0]        word;
        logic               high;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } tpq_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds the two levels and the results still awaited
    // ------------------------------------------------------------------------
    class prio_fifo_scoreboard;
        logic [15:0]  high_words[$];
        logic [15:0]  low_words[$];
        tpq_result_t  awaited[$];
        int unsigned  failures;

        // work out the result of one accepted request
        function void note_request(logic req, logic [15:0] word, logic hi);
            tpq_result_t res;
            int unsigned held;
            res = '0;
            res.status = ST_OK;
            held = high_words.size() + low_words.size();
            if (req == REQ_ENQ) begin
                if (held >= FIFO_CAPACITY)
                    res.status = ST_FULL;
                else if (hi)
                    high_words.push_back(word);
                else
                    low_words.push_back(word);
            end else if (high_words.size() != 0) begin
                res.word = high_words.pop_front();
                res.high = 1'b1;
            end else if (low_words.size() != 0) begin
                res.word = low_words.pop_front();
            end else begin
                res.status = ST_EMPTY;
            end
            held = high_words.size() + low_words.size();
            res.count = held[COUNT_W-1:0];
            res.empty = (held == 0);
            awaited.push_back(res);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(logic [23:0] tdata, logic [0:0] tuser);
            tpq_result_t exp_res;
            if (awaited.size() == 0) begin
                $error("result beat with nothing expected: tdata %h tuser %h", tdata, tuser);
                failures++;
                return;
            end
            exp_res = awaited.pop_front();
            if (tdata[15:0] !== exp_res.word) begin
                $error("out_data: expected %h, got %h", exp_res.word, tdata[15:0]);
                failures++;
            end
            if (tuser[0] !== exp_res.high) begin
                $error("out_high: expected %0d, got %0d", exp_res.high, tuser[0]);
                failures++;
            end
            if (tdata[17:16] !== exp_res.status) begin
                $error("status: expected %0d, got %0d", exp_res.status, tdata[17:16]);
                failures++;
            end
            if (tdata[22:18] !== exp_res.count) begin
                $error("item_count: expected %0d, got %0d", exp_res.count, tdata[22:18]);
                failures++;
            end
            if (tdata[23] !== exp_res.empty) begin
                $error("queue_empty: expected %0d, got %0d", exp_res.empty, tdata[23]);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_tvalid = 1'b0;
    logic        req_tready;
    logic [15:0] req_tdata = '0;   // item_data
    logic [1:0]  req_tuser = '0;   // req_type, is_high
    logic        res_tvalid;
    logic        res_tready = 1'b0;
    logic [23:0] res_tdata;        // out_data, status, item_count, queue_empty
    logic [0:0]  res_tuser;        // out_high

    prio_fifo_scoreboard sb = new();

    rx_pace_e    rx_pace = RX_FREE;
    int unsigned rx_left = 0;
    int unsigned burst_left = 0;

    two_level_priority_fifo #(
        .CAPACITY   (FIFO_CAPACITY),
        .DATA_WIDTH (16)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_tvalid),
        .o_s_axis_tready (req_tready),
        .i_s_axis_tdata  (req_tdata),
        .i_s_axis_tuser  (req_tuser),
        .o_m_axis_tvalid (res_tvalid),
        .i_m_axis_tready (res_tready),
        .o_m_axis_tdata  (res_tdata),
        .o_m_axis_tuser  (res_tuser)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Receiver: check accepted beats, then pick next tready from the pattern
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && res_tvalid && res_tready)
            sb.check_result(res_tdata, res_tuser);
        if (rx_left == 0) begin
            rx_pace <= rx_pace_e'($urandom_range(0, 3));
            rx_left <= $urandom_range(4, 40);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_pace)
            RX_FREE:   res_tready <= 1'b1;
            RX_MOSTLY: res_tready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: res_tready <= ($urandom_range(0, 3) == 0);
            default:   res_tready <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sender tasks; each is entered and left just after a rising edge
    // ------------------------------------------------------------------------

    // drive one request beat and hold it until accepted
    task automatic send_request(input logic req, input logic [15:0] word, input logic hi);
        req_tvalid <= 1'b1;
        req_tdata  <= word;
        req_tuser  <= {hi, req};
        do @(posedge clk); while (!req_tready);
        sb.note_request(req, word, hi);
    endtask

    // same, with the sender working in bursts and pausing between them
    task automatic send_paced(input logic req, input logic [15:0] word, input logic hi);
        if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            // now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        send_request(req, word, hi);
        burst_left--;
    endtask

    // hold off until every expected result beat has come back
    task automatic wait_all_results();
        req_tvalid <= 1'b0;
        do @(posedge clk); while (sb.awaited.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned sent;
        int unsigned phase_len;
        int unsigned enq_pct;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // dequeue with nothing held, with data and level set to be ignored
        send_request(REQ_DEQ, 16'hFFFF, 1'b1);
        // both levels, word extremes; high level must leave first
        send_request(REQ_ENQ, 16'h0000, 1'b0);
        send_request(REQ_ENQ, 16'hFFFF, 1'b1);
        send_request(REQ_DEQ, 16'h0000, 1'b0);
        send_request(REQ_DEQ, 16'h0000, 1'b0);
        send_request(REQ_DEQ, 16'h0000, 1'b0);
        // fill to capacity with mixed levels, then enqueue twice when full
        for (int i = 0; i < FIFO_CAPACITY; i++)
            send_request(REQ_ENQ, 16'h8000 >> i, (i % 3) != 0);
        send_request(REQ_ENQ, 16'hFFFF, 1'b1);
        send_request(REQ_ENQ, 16'h0000, 1'b0);
        wait_all_results();

        // random phases leaning towards fill, drain or a mix
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                default: enq_pct = 50;
            endcase
            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                send_paced(($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ,
                           16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
                sent++;
            end
            if (sent >= RANDOM_ITEMS / 2 && sent - phase_len < RANDOM_ITEMS / 2)
                wait_all_results();
        end

        // drain, then allow for anything stray from the pipeline
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.awaited.size() != 0) begin
            $error("%0d result beats never arrived", sb.awaited.size());
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
